// ===== sv/infix_to_postfix_converter_defines.svh =====
// Assertion macros used by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/itp_pkg.sv =====
package itp_pkg;

   // Operator stack geometry
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // Field widths
   localparam int TYPE_W = 2;
   localparam int NUM_W  = 31;
   localparam int OP_W   = 3;
   localparam int KIND_W = 2;
   localparam int ERR_W  = 3;

   // Token types
   localparam logic [TYPE_W-1:0] TYPE_NUMBER   = 2'd0;
   localparam logic [TYPE_W-1:0] TYPE_OPERATOR = 2'd1;
   localparam logic [TYPE_W-1:0] TYPE_END      = 2'd2;

   // Operator codes
   localparam logic [OP_W-1:0] OP_OPEN  = 3'd0;
   localparam logic [OP_W-1:0] OP_CLOSE = 3'd1;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd2;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd3;
   localparam logic [OP_W-1:0] OP_MUL   = 3'd4;
   localparam logic [OP_W-1:0] OP_DIV   = 3'd5;
   localparam logic [OP_W-1:0] OP_POW   = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD   = 3'd7;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_NUM = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OP  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_OK  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ERR = 2'd3;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_CLOSE    = 3'd1;
   localparam logic [ERR_W-1:0] ERR_OPEN     = 3'd2;
   localparam logic [ERR_W-1:0] ERR_INVALID  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_OVERFLOW = 3'd4;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [NUM_W-1:0]  number;
      logic [OP_W-1:0]   oper;
      logic [ERR_W-1:0]  err;
   } result_type;

   // Binding strength: + - weakest, ^ strongest, parentheses none
   function automatic logic [1:0] strength(input logic [OP_W-1:0] op);
      logic [1:0] s;
      case (op)
         OP_ADD, OP_SUB: s = 2'd1;
         OP_MUL, OP_DIV: s = 2'd2;
         OP_POW:         s = 2'd3;
         default:        s = 2'd0;
      endcase
      return s;
   endfunction

   function automatic result_type make_result(input logic [KIND_W-1:0] kind,
                                              input logic [NUM_W-1:0]  number,
                                              input logic [OP_W-1:0]   oper,
                                              input logic [ERR_W-1:0]  err);
      result_type r;
      r.kind   = kind;
      r.number = number;
      r.oper   = oper;
      r.err    = err;
      return r;
   endfunction

endpackage

// ===== sv/itp_ram.sv =====
module itp_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port, registered read port that holds when not enabled
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/infix_to_postfix_converter.sv =====
// Shunting-yard converter: takes one infix token per req_ transaction (number, operator or
// parenthesis, end mark) and returns the postfix stream on rsp_, with rsp_last set on the
// final result that a token causes; an end mark closes with an ok or an error result unless
// tokens are being dropped after an error, and after an error tokens are dropped until the
// end mark. Operators wait in a 16-entry stack held in a single-port-read RAM with a registered
// read, and the stack top is looked at through that read port one entry per cycle while the
// result staging can take a result. A token passes through accept, execute and hand-over of
// the last result, with a pop step for every stacked entry it examines, and a tail step when a
// pop run empties the stack and a closing result follows; each operator is pushed once and
// popped at most once. New tokens are taken while the final result of the previous token
// still waits in the output register.
`include "infix_to_postfix_converter_defines.svh"

module infix_to_postfix_converter (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [itp_pkg::TYPE_W-1:0] req_type,
   input  logic [itp_pkg::NUM_W-1:0]  req_number_value,
   input  logic [itp_pkg::OP_W-1:0]   req_operator_code,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [itp_pkg::KIND_W-1:0] rsp_out_kind,
   output logic [itp_pkg::NUM_W-1:0]  rsp_out_number,
   output logic [itp_pkg::OP_W-1:0]   rsp_out_operator,
   output logic [itp_pkg::ERR_W-1:0]  rsp_error_code,
   output logic                       rsp_last
);

   import itp_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_EXEC = 5'b00010,
      S_POP  = 5'b00100,
      S_TAIL = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              disc_ff, disc_in;
   logic [TYPE_W-1:0] tok_type_ff;
   logic [NUM_W-1:0]  tok_num_ff;
   logic [OP_W-1:0]   tok_op_ff;
   result_type        pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   result_type        out_ff, out_in;
   logic              out_last_ff, out_last_in;
   logic              out_valid_ff, out_valid_in;

   logic              ram_wr_en;
   logic [PTR_W-1:0]  ram_wr_addr;
   logic              ram_rd_en;
   logic [PTR_W-1:0]  ram_rd_addr;
   logic [OP_W-1:0]   top;

   logic              put_en;
   result_type        put_res;
   logic              fin_en;
   logic              out_free;
   logic              step_ok;
   logic              is_full;
   logic              top_wins;
   logic [CNT_W-1:0]  cnt_m1;
   logic [CNT_W-1:0]  cnt_m2;

   // Operator stack storage
   itp_ram #(
      .WIDTH(OP_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(tok_op_ff),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(top)
   );

   // Handshake helpers and stack arithmetic
   assign out_free = !out_valid_ff || rsp_ready;
   assign step_ok  = !pend_valid_ff || out_free;
   assign is_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign cnt_m1   = count_ff - CNT_W'(1);
   assign cnt_m2   = count_ff - CNT_W'(2);
   assign top_wins = (top != OP_OPEN) &&
                     ((strength(top) > strength(tok_op_ff)) ||
                      ((strength(top) == strength(tok_op_ff)) && (tok_op_ff != OP_POW)));

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: one stack entry examined per cycle unless the result staging is full, results staged through pend_ff
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      disc_in     = disc_ff;
      put_en      = 1'b0;
      put_res     = make_result(KIND_NUM, '0, OP_OPEN, ERR_NONE);
      fin_en      = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cnt_m1[PTR_W-1:0];
      ram_wr_en   = 1'b0;
      ram_wr_addr = count_ff[PTR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            state_in = S_FIN;
            case (tok_type_ff)
               TYPE_NUMBER: begin
                  if (!disc_ff) begin
                     put_en  = 1'b1;
                     put_res = make_result(KIND_NUM, tok_num_ff, OP_OPEN, ERR_NONE);
                  end
               end
               TYPE_END: begin
                  if (disc_ff) begin
                     disc_in  = 1'b0;
                     count_in = '0;
                  end else if (count_ff == '0) begin
                     put_en  = 1'b1;
                     put_res = make_result(KIND_OK, '0, OP_OPEN, ERR_NONE);
                  end else begin
                     ram_rd_en = 1'b1;
                     state_in  = S_POP;
                  end
               end
               TYPE_OPERATOR: begin
                  if (!disc_ff) begin
                     case (tok_op_ff)
                        OP_OPEN: begin
                           if (is_full) begin
                              put_en   = 1'b1;
                              put_res  = make_result(KIND_ERR, '0, OP_OPEN, ERR_OVERFLOW);
                              count_in = '0;
                              disc_in  = 1'b1;
                           end else begin
                              ram_wr_en = 1'b1;
                              count_in  = count_ff + CNT_W'(1);
                           end
                        end
                        OP_CLOSE: begin
                           if (count_ff == '0) begin
                              put_en  = 1'b1;
                              put_res = make_result(KIND_ERR, '0, OP_OPEN, ERR_CLOSE);
                              disc_in = 1'b1;
                           end else begin
                              ram_rd_en = 1'b1;
                              state_in  = S_POP;
                           end
                        end
                        OP_BAD: begin
                           put_en   = 1'b1;
                           put_res  = make_result(KIND_ERR, '0, OP_OPEN, ERR_INVALID);
                           count_in = '0;
                           disc_in  = 1'b1;
                        end
                        default: begin
                           if (count_ff == '0) begin
                              ram_wr_en = 1'b1;
                              count_in  = CNT_W'(1);
                           end else begin
                              ram_rd_en = 1'b1;
                              state_in  = S_POP;
                           end
                        end
                     endcase
                  end
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end

         S_POP: begin
            if (step_ok) begin
               ram_rd_addr = cnt_m2[PTR_W-1:0];
               case (tok_type_ff)
                  TYPE_OPERATOR: begin
                     if (tok_op_ff == OP_CLOSE) begin
                        count_in = cnt_m1;
                        if (top == OP_OPEN) begin
                           state_in = S_FIN;
                        end else begin
                           put_en  = 1'b1;
                           put_res = make_result(KIND_OP, '0, top, ERR_NONE);
                           if (cnt_m1 == '0) begin
                              state_in = S_TAIL;
                           end else begin
                              ram_rd_en = 1'b1;
                           end
                        end
                     end else if (!top_wins) begin
                        // Stop popping and push the incoming operator, or report overflow if the stack is full
                        state_in = S_FIN;
                        if (is_full) begin
                           put_en   = 1'b1;
                           put_res  = make_result(KIND_ERR, '0, OP_OPEN, ERR_OVERFLOW);
                           count_in = '0;
                           disc_in  = 1'b1;
                        end else begin
                           ram_wr_en = 1'b1;
                           count_in  = count_ff + CNT_W'(1);
                        end
                     end else begin
                        put_en  = 1'b1;
                        put_res = make_result(KIND_OP, '0, top, ERR_NONE);
                        if (cnt_m1 == '0) begin
                           // Stack now empty: the push replaces the popped entry
                           ram_wr_en   = 1'b1;
                           ram_wr_addr = cnt_m1[PTR_W-1:0];
                           state_in    = S_FIN;
                        end else begin
                           count_in  = cnt_m1;
                           ram_rd_en = 1'b1;
                        end
                     end
                  end
                  TYPE_END: begin
                     count_in = cnt_m1;
                     put_en   = 1'b1;
                     if ((top == OP_OPEN) || (top == OP_CLOSE)) begin
                        put_res  = make_result(KIND_ERR, '0, OP_OPEN, ERR_OPEN);
                        count_in = '0;
                        state_in = S_FIN;
                     end else begin
                        put_res = make_result(KIND_OP, '0, top, ERR_NONE);
                        if (cnt_m1 == '0) begin
                           state_in = S_TAIL;
                        end else begin
                           ram_rd_en = 1'b1;
                        end
                     end
                  end
                  default: begin
                     state_in = S_FIN;
                  end
               endcase
            end
         end

         S_TAIL: begin
            // Stack ran empty: close with ok at the end mark, else an unmatched close
            if (step_ok) begin
               put_en   = 1'b1;
               state_in = S_FIN;
               if (tok_type_ff == TYPE_END) begin
                  put_res = make_result(KIND_OK, '0, OP_OPEN, ERR_NONE);
               end else begin
                  put_res = make_result(KIND_ERR, '0, OP_OPEN, ERR_CLOSE);
                  disc_in = 1'b1;
               end
            end
         end

         S_FIN: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               fin_en   = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result staging: a held result goes out once the next one, or the token end, is known
   always_comb begin
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      if (put_en) begin
         if (pend_valid_ff) begin
            out_in       = pend_ff;
            out_last_in  = 1'b0;
            out_valid_in = 1'b1;
         end
         pend_in       = put_res;
         pend_valid_in = 1'b1;
      end
      if (fin_en) begin
         out_in        = pend_ff;
         out_last_in   = 1'b1;
         out_valid_in  = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         disc_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         disc_ff       <= disc_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         tok_type_ff <= req_type;
         tok_num_ff  <= req_number_value;
         tok_op_ff   <= req_operator_code;
      end
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_kind     = out_ff.kind;
   assign rsp_out_number   = out_ff.number;
   assign rsp_out_operator = out_ff.oper;
   assign rsp_error_code   = out_ff.err;
   assign rsp_last         = out_last_ff;

   // Checks
   `ITP_ASSERT_NOW(a_pop_nonempty, state_ff == S_POP, count_ff != '0, "pop on empty stack")
   `ITP_ASSERT_NOW(a_idle_drained, req_ready, !pend_valid_ff, "new token with result held")
   `ITP_ASSERT_NOW(a_write_in_range, ram_wr_en, !is_full && (state_ff != S_TAIL),
                   "stack write beyond depth")
   `ITP_ASSERT_NEXT(a_error_discards, put_en && (put_res.kind == KIND_ERR) && (put_res.err != ERR_OPEN),
                    disc_ff && (count_ff == '0), "error without discard")

endmodule
